// ===== sv/sorted_event_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_event_queue_macros
// Assertion macros shared by the sorted event queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_QUEUE_MACROS_SVH
`define SORTED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication on clk_i, disabled in reset
`define SEVQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, disabled in reset
`define SEVQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sevq_pkg.sv =====
// ----------------------------------------------------------------------------
// sevq_pkg
// Types, constants and index helpers of the sorted event queue.
// ----------------------------------------------------------------------------
package sevq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int TYPE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int OCC_W    = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [TYPE_W-1:0] ev_type;
    logic [TIME_W-1:0] ev_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              valid;
    logic [TYPE_W-1:0] out_type;
    logic [TIME_W-1:0] out_time;
    logic              found;
    logic              dropped;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  function automatic idx_t idx_inc(idx_t a);
    return (a == IDX_W'(CAPACITY - 1)) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic idx_t idx_dec(idx_t a);
    return (a == '0) ? IDX_W'(CAPACITY - 1) : a - IDX_W'(1);
  endfunction

  function automatic idx_t idx_add(idx_t a, cnt_t b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_of(cnt_t c);
    logic [CNT_W+OCC_W-1:0] w;
    w = (CNT_W + OCC_W)'(c);
    return w[OCC_W-1:0];
  endfunction

endpackage

// ===== sv/sevq_req_if.sv =====
// ----------------------------------------------------------------------------
// sevq_req_if
// Request channel of the sorted event queue: insert or pop.
// ----------------------------------------------------------------------------
interface sevq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [sevq_pkg::TYPE_W-1:0] event_type;
  logic [sevq_pkg::TIME_W-1:0] event_time;

  modport source (output valid, output mode, output event_type, output event_time,
                  input ready);
  modport sink   (input valid, input mode, input event_type, input event_time,
                  output ready);
endinterface

// ===== sv/sevq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sevq_rsp_if
// Result channel of the sorted event queue.
// ----------------------------------------------------------------------------
interface sevq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sevq_pkg::TYPE_W-1:0] out_type;
  logic [sevq_pkg::TIME_W-1:0] out_time;
  logic                       found;
  logic                       dropped;
  logic [sevq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output out_type, output out_time, output found,
                  output dropped, output occupancy, input ready);
  modport sink   (input valid, input out_type, input out_time, input found,
                  input dropped, input occupancy, output ready);
endinterface

// ===== sv/sevq_ram.sv =====
// ----------------------------------------------------------------------------
// sevq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/sevq_core.sv =====
// ----------------------------------------------------------------------------
// sevq_core
// Sequencer over a circular entry store: insert by one compare-and-shift
// step per cycle from the tail, pop by advancing the head.
// ----------------------------------------------------------------------------
module sevq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 mode_i,
  input  sevq_pkg::entry_t     new_i,
  output logic                 idle_o,
  output sevq_pkg::result_t    res_o,
  output logic                 we_o,
  output sevq_pkg::idx_t       waddr_o,
  output sevq_pkg::entry_t     wdata_o,
  output sevq_pkg::idx_t       raddr_o,
  input  sevq_pkg::entry_t     rdata_i
);

  import sevq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_PLACE,
    S_POP
  } state_e;

  state_e state_q, state_d;
  logic   op_q, op_d;
  idx_t   head_q, head_d;
  cnt_t   count_q, count_d;
  idx_t   wr_ptr_q, wr_ptr_d;
  idx_t   rd_ptr_q, rd_ptr_d;
  cnt_t   left_q, left_d;
  entry_t new_q, new_d;

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    head_d   = head_q;
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    left_d   = left_q;
    new_d    = new_q;
    we_o     = 1'b0;
    waddr_o  = wr_ptr_q;
    wdata_o  = new_q;
    raddr_o  = rd_ptr_q;
    res_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = mode_i;
          new_d = new_i;
          if (mode_i == MODE_POP) begin
            if (count_q == '0) begin
              res_o.valid = 1'b1;
            end else begin
              rd_ptr_d = head_q;
              state_d  = S_READ;
            end
          end else if (count_q == CNT_W'(CAPACITY)) begin
            res_o.valid   = 1'b1;
            res_o.dropped = 1'b1;
          end else if (count_q == '0) begin
            we_o        = 1'b1;
            waddr_o     = head_q;
            wdata_o     = new_i;
            count_d     = count_q + CNT_W'(1);
            res_o.valid = 1'b1;
          end else begin
            wr_ptr_d = idx_add(head_q, count_q);
            rd_ptr_d = idx_dec(idx_add(head_q, count_q));
            left_d   = count_q;
            state_d  = S_READ;
          end
          res_o.occupancy = occ_of(count_d);
        end
      end
      S_READ: begin
        raddr_o = rd_ptr_q;
        state_d = (op_q == MODE_POP) ? S_POP : S_CMP;
      end
      S_CMP: begin
        if (rdata_i.ev_time > new_q.ev_time) begin
          we_o     = 1'b1;
          waddr_o  = wr_ptr_q;
          wdata_o  = rdata_i;
          wr_ptr_d = rd_ptr_q;
          left_d   = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = S_PLACE;
          end else begin
            rd_ptr_d = idx_dec(rd_ptr_q);
            raddr_o  = idx_dec(rd_ptr_q);
          end
        end else begin
          we_o            = 1'b1;
          count_d         = count_q + CNT_W'(1);
          res_o.valid     = 1'b1;
          res_o.occupancy = occ_of(count_d);
          state_d         = S_IDLE;
        end
      end
      S_PLACE: begin
        we_o            = 1'b1;
        count_d         = count_q + CNT_W'(1);
        res_o.valid     = 1'b1;
        res_o.occupancy = occ_of(count_d);
        state_d         = S_IDLE;
      end
      S_POP: begin
        head_d          = idx_inc(head_q);
        count_d         = count_q - CNT_W'(1);
        res_o.valid     = 1'b1;
        res_o.found     = 1'b1;
        res_o.out_type  = rdata_i.ev_type;
        res_o.out_time  = rdata_i.ev_time;
        res_o.occupancy = occ_of(count_d);
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= MODE_INSERT;
      head_q   <= '0;
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      left_q   <= '0;
      new_q    <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      head_q   <= head_d;
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      left_q   <= left_d;
      new_q    <= new_d;
    end
  end

endmodule

// ===== sv/sorted_event_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_event_queue
// Time-ordered event queue: insert (type, Q16.16 time), pop earliest.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: mode 0 inserts {event_type, event_time},
//   mode 1 pops the earliest entry. Equal times leave in arrival order.
//   rsp_o returns exactly one result per request: the popped entry with
//   found, the dropped flag for an insert into a full queue, and the
//   occupancy after the request.
//   Sequencing: a pop on an empty queue and an insert into an empty or full
//   queue are answered from the idle state; a pop reads the head entry;
//   any other insert reads from the tail and shifts up each entry later than
//   the new time, by the single compare-and-shift step on the entry RAM per cycle.
//   One request is in flight at a time; req_i.ready is low while it works.
//   The result sits in an output register; a new request is taken while
//   it waits only if rsp_o.ready drains it in the same cycle.
//   Reset empties the queue at once; entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
`include "sorted_event_queue_macros.svh"

module sorted_event_queue (
  input logic         clk_i,
  input logic         rst_ni,
  sevq_req_if.sink    req_i,
  sevq_rsp_if.source  rsp_o
);

  import sevq_pkg::*;

  logic    core_idle;
  logic    start;
  result_t core_res;
  entry_t  new_entry;
  logic    ram_we;
  idx_t    ram_waddr;
  entry_t  ram_wdata;
  idx_t    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic    out_valid_q;
  result_t out_res_q;

  assign req_i.ready         = core_idle && (!out_valid_q || rsp_o.ready);
  assign start               = req_i.valid && req_i.ready;
  assign new_entry.ev_type   = req_i.event_type;
  assign new_entry.ev_time   = req_i.event_time;

  sevq_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (req_i.mode),
    .new_i   (new_entry),
    .idle_o  (core_idle),
    .res_o   (core_res),
    .we_o    (ram_we),
    .waddr_o (ram_waddr),
    .wdata_o (ram_wdata),
    .raddr_o (ram_raddr),
    .rdata_i (entry_t'(ram_rdata))
  );

  sevq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res.valid) begin
      out_res_q <= core_res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_type  = out_res_q.out_type;
  assign rsp_o.out_time  = out_res_q.out_time;
  assign rsp_o.found     = out_res_q.found;
  assign rsp_o.dropped   = out_res_q.dropped;
  assign rsp_o.occupancy = out_res_q.occupancy;

  `SEVQ_ASSERT_IMP(a_no_overwrite, core_res.valid, !out_valid_q || rsp_o.ready, "result overwrites a pending one")
  `SEVQ_ASSERT_NXT(a_idle_after_res, core_res.valid, core_idle, "sequencer busy after result")
  `SEVQ_ASSERT_IMP(a_flags_excl, out_valid_q, !(rsp_o.found && rsp_o.dropped), "found and dropped both set")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted event queue. Requests (insert or pop)
// are driven on req_if and predicted against a time-sorted shadow list; each
// result on rsp_if is checked in order. Traffic mixes fill, drain and
// balanced bursts under several sender and receiver idle patterns, with one
// long receiver hold-off that backs the queue up.
// ----------------------------------------------------------------------------
module tb_top;
  import sevq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic              mode;
    logic [TYPE_W-1:0] ev_type;
    logic [TIME_W-1:0] ev_time;
  } request_t;

  typedef struct packed {
    logic [TYPE_W-1:0] ev_type;
    logic [TIME_W-1:0] ev_time;
    logic              found;
    logic              dropped;
    logic [OCC_W-1:0]  occupancy;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sevq_req_if req_if ();
  sevq_rsp_if rsp_if ();

  sorted_event_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  entry_t      shadow_entries[CAPACITY];
  int unsigned event_count;
  int unsigned fault_cnt;
  int unsigned cycle_cnt;
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  logic        rx_hold;

  always #4 clk_i = ~clk_i;

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       pos;
    int       k;
    o = '0;
    if (r.mode == MODE_INSERT) begin
      if (event_count >= CAPACITY) begin
        o.dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < event_count && shadow_entries[pos].ev_time <= r.ev_time) pos++;
        for (k = event_count; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[pos].ev_type = r.ev_type;
        shadow_entries[pos].ev_time = r.ev_time;
        event_count++;
      end
    end else if (event_count > 0) begin
      o.ev_type = shadow_entries[0].ev_type;
      o.ev_time = shadow_entries[0].ev_time;
      o.found   = 1'b1;
      for (k = 1; k < event_count; k++) shadow_entries[k-1] = shadow_entries[k];
      event_count--;
    end
    o.occupancy = OCC_W'(event_count);
    return o;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time(int unsigned style);
    case (style)
      0: return TIME_W'($urandom);
      1: return {16'($urandom_range(3)), 14'd0, 2'($urandom_range(3))};
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 32'h0000_FFFF;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return {8'($urandom_range(255)), 24'($urandom)} ^ 32'h8000_0000;
    endcase
  endfunction

  function automatic void queue_request(logic mode, logic [TYPE_W-1:0] ty,
                                        logic [TIME_W-1:0] tm);
    request_t r;
    r.mode    = mode;
    r.ev_type = ty;
    r.ev_time = tm;
    pending_requests.push_back(r);
  endfunction

  task automatic queue_mixed_traffic(int unsigned n);
    int unsigned left;
    int unsigned seg;
    int unsigned ins_pct;
    int unsigned style;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(40, 8);
      if (seg > left) seg = left;
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 20;
      endcase
      style = $urandom_range(3);
      repeat (seg) begin
        if ($urandom_range(99) < ins_pct) begin
          queue_request(MODE_INSERT, TYPE_W'($urandom), pick_time(style));
        end else begin
          queue_request(MODE_POP, TYPE_W'($urandom), TIME_W'($urandom));
        end
      end
      left -= seg;
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(int unsigned snd, int unsigned rcv, int unsigned n, bit hold);
    @(posedge clk_i);
    snd_idle_pct  <= snd;
    rcv_stall_pct <= rcv;
    if (hold) begin
      rx_hold <= 1'b1;
      fork
        begin
          repeat (HOLD_CYCLES) @(posedge clk_i);
          rx_hold <= 1'b0;
        end
      join_none
    end
    queue_mixed_traffic(n);
    wait_drained();
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin : drive
      request_t nxt;
      if (req_if.valid) begin
        expected_outcomes.push_back(apply_request(pending_requests.pop_front()));
      end
      if (pending_requests.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = pending_requests[0];
        req_if.valid      <= 1'b1;
        req_if.mode       <= nxt.mode;
        req_if.event_type <= nxt.ev_type;
        req_if.event_time <= nxt.ev_time;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin : watch
      outcome_t got;
      outcome_t want;
      if (rsp_if.valid && rsp_if.ready) begin
        got.ev_type   = rsp_if.out_type;
        got.ev_time   = rsp_if.out_time;
        got.found     = rsp_if.found;
        got.dropped   = rsp_if.dropped;
        got.occupancy = rsp_if.occupancy;
        if (expected_outcomes.size() == 0) begin
          if (fault_cnt < 10) begin
            $display("unexpected result: type=%h time=%h found=%b dropped=%b occ=%0d",
                     got.ev_type, got.ev_time, got.found, got.dropped, got.occupancy);
          end
          fault_cnt++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.ev_type !== want.ev_type || got.ev_time !== want.ev_time ||
              got.found !== want.found || got.dropped !== want.dropped ||
              got.occupancy !== want.occupancy) begin
            if (fault_cnt < 10) begin
              $display("mismatch: exp type=%h time=%h found=%b dropped=%b occ=%0d",
                       want.ev_type, want.ev_time, want.found, want.dropped,
                       want.occupancy);
              $display("          got type=%h time=%h found=%b dropped=%b occ=%0d",
                       got.ev_type, got.ev_time, got.found, got.dropped, got.occupancy);
            end
            fault_cnt++;
          end
        end
      end
      rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_INSERT;
    req_if.event_type = '0;
    req_if.event_time = '0;
    rsp_if.ready      = 1'b0;
    rx_hold           = 1'b0;
    snd_idle_pct      = 0;
    rcv_stall_pct     = 0;
    fault_cnt         = 0;
    cycle_cnt         = 0;
    event_count       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pop empty, extremes, equal times leaving in arrival order, drain past empty
    queue_request(MODE_POP, 8'hFF, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 8'hFF, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 8'h00, 32'h0000_0000);
    queue_request(MODE_INSERT, 8'hA5, 32'h8000_0000);
    queue_request(MODE_INSERT, 8'h01, 32'h0001_0000);
    queue_request(MODE_INSERT, 8'h02, 32'h0001_0000);
    queue_request(MODE_INSERT, 8'h03, 32'h0001_0000);
    queue_request(MODE_INSERT, 8'h5A, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 8'h04, 32'h0001_0000);
    repeat (9) queue_request(MODE_POP, 8'h00, 32'h0000_0000);
    wait_drained();

    run_phase(0, 0, 400, 1'b0);
    run_phase(58, 0, 400, 1'b0);
    run_phase(0, 58, 400, 1'b0);
    run_phase(9, 9, 300, 1'b0);
    run_phase(0, 0, 200, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0 && expected_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
